// File: rtl/frdf_pkg.sv
package frdf_pkg;

   localparam int SEEN_DEPTH = 256;
   localparam int SEEN_AGE_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam int SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);

   localparam int SEQ_W = 8;

   localparam logic [7:0] TYPE_FORM    = 8'd0;
   localparam logic [7:0] TYPE_LED_ON  = 8'd1;
   localparam logic [7:0] TYPE_LED_OFF = 8'd2;

   localparam logic [7:0] MAX_HOPS_RESET = 8'd3;

   typedef enum logic [2:0] {
      ST_RELAYED     = 3'd0,
      ST_EXPIRED     = 3'd1,
      ST_DUPLICATE   = 3'd2,
      ST_INVALID     = 3'd3,
      ST_IGNORED     = 3'd4,
      ST_ORIGINATED  = 3'd5,
      ST_BTN_IGNORED = 3'd6
   } status_type;

   typedef struct packed {
      logic             shift;
      logic             rotate;
      logic [SEQ_W-1:0] entry;
   } chain_ctrl_type;

endpackage

// File: rtl/frdf_cell.sv
module frdf_cell (
   input  logic                    clock,
   input  logic                    shift,
   input  logic [frdf_pkg::SEQ_W-1:0] d_in,
   output logic [frdf_pkg::SEQ_W-1:0] q_out
);

   logic [frdf_pkg::SEQ_W-1:0] entry_ff;
   logic [frdf_pkg::SEQ_W-1:0] entry_in;

   always_comb begin
      entry_in = shift ? d_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q_out = entry_ff;

endmodule

// File: rtl/frdf_chain.sv
module frdf_chain (
   input  logic                          clock,
   input  frdf_pkg::chain_ctrl_type      ctrl,
   output logic [frdf_pkg::SEQ_W-1:0]    tail
);

   logic [frdf_pkg::SEQ_W-1:0] cell_q [frdf_pkg::SEEN_DEPTH];
   logic [frdf_pkg::SEQ_W-1:0] head_in;

   // Cell 0 holds the newest entry; a rotation feeds the tail back to the head.
   assign head_in = ctrl.rotate ? cell_q[frdf_pkg::SEEN_DEPTH-1] : ctrl.entry;

   for (genvar i = 0; i < frdf_pkg::SEEN_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         frdf_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .d_in  (head_in),
            .q_out (cell_q[i])
         );
      end else begin : g_body
         frdf_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .d_in  (cell_q[i-1]),
            .q_out (cell_q[i])
         );
      end
   end

   assign tail = cell_q[frdf_pkg::SEEN_DEPTH-1];

endmodule

// File: rtl/flood_relay_duplicate_filter_top.sv
// A button beat or an ignored frame goes from acceptance to S_FINISH and then to the
// result register; a frame that is searched passes S_SEARCH before S_FINISH.
// Throughput: one beat at a time; a searched frame occupies the block while the search
// rotates the whole cell chain once, one entry a cycle, and holds S_FINISH while stalled.
// Reset is synchronous and clears the control state; the seen cells are not cleared,
// and only entries below the fill count are ever compared.
module flood_relay_duplicate_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // is_vendor_data, rx_type[8:1], rx_seq[16:9], rx_ttl[24:17], button_level[25]
   input  logic [31:0] req_tdata,
   // op
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_valid, tx_type[8:1], tx_seq[16:9], tx_ttl[24:17], led_on[25], joined[26],
   // initiator[27], status[30:28]
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       op;
      logic       vendor;
      logic [7:0] rtype;
      logic [7:0] rseq;
      logic [7:0] rttl;
      logic       level;
   } item_type;

   state_type                       state_ff, state_in;
   item_type                        item_ff, item_in;
   logic [frdf_pkg::SEEN_AGE_W-1:0] age_ff, age_in;
   logic [frdf_pkg::SEEN_CNT_W-1:0] count_ff, count_in;
   logic                            found_ff, found_in;
   logic [7:0]                      next_seq_ff, next_seq_in;
   logic                            net_ff, net_in;
   logic                            orig_ff, orig_in;
   logic                            led_ff, led_in;
   logic [7:0]                      max_hops_ff, max_hops_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [31:0]                     rsp_data_ff, rsp_data_in;

   frdf_pkg::chain_ctrl_type        chain_ctrl;
   logic [frdf_pkg::SEQ_W-1:0]      chain_tail;

   logic                            out_free;
   logic                            tx_valid;
   logic [7:0]                      tx_type, tx_seq, tx_ttl;
   frdf_pkg::status_type            status;
   logic                            record;

   frdf_chain u_chain (
      .clock (clock),
      .ctrl  (chain_ctrl),
      .tail  (chain_tail)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Event decision and the state that follows from it.
   always_comb begin
      tx_valid    = 1'b0;
      tx_type     = 8'd0;
      tx_seq      = 8'd0;
      tx_ttl      = 8'd0;
      status      = frdf_pkg::ST_IGNORED;
      record      = 1'b0;
      next_seq_in = next_seq_ff;
      net_in      = net_ff;
      orig_in     = orig_ff;
      led_in      = led_ff;
      if (item_ff.op) begin
         if (!net_ff) begin
            net_in      = 1'b1;
            orig_in     = 1'b1;
            tx_valid    = 1'b1;
            tx_type     = frdf_pkg::TYPE_FORM;
            tx_seq      = next_seq_ff;
            tx_ttl      = max_hops_ff;
            next_seq_in = next_seq_ff + 8'd1;
            status      = frdf_pkg::ST_ORIGINATED;
         end else if (orig_ff) begin
            led_in      = !item_ff.level;
            tx_valid    = 1'b1;
            tx_type     = item_ff.level ? frdf_pkg::TYPE_LED_OFF : frdf_pkg::TYPE_LED_ON;
            tx_seq      = next_seq_ff;
            tx_ttl      = max_hops_ff;
            next_seq_in = next_seq_ff + 8'd1;
            status      = frdf_pkg::ST_ORIGINATED;
         end else begin
            status = frdf_pkg::ST_BTN_IGNORED;
         end
      end else if (orig_ff || !item_ff.vendor) begin
         status = frdf_pkg::ST_IGNORED;
      end else if (found_ff) begin
         status = frdf_pkg::ST_DUPLICATE;
      end else begin
         record = 1'b1;
         status = (item_ff.rttl != 8'd0) ? frdf_pkg::ST_RELAYED : frdf_pkg::ST_EXPIRED;
         unique case (item_ff.rtype)
            frdf_pkg::TYPE_FORM: begin
               net_in  = 1'b1;
               orig_in = 1'b0;
            end
            frdf_pkg::TYPE_LED_ON: begin
               led_in = 1'b1;
            end
            frdf_pkg::TYPE_LED_OFF: begin
               led_in = 1'b0;
            end
            default: begin
               status = frdf_pkg::ST_INVALID;
            end
         endcase
         if (status == frdf_pkg::ST_RELAYED) begin
            tx_valid = 1'b1;
            tx_type  = item_ff.rtype;
            tx_seq   = item_ff.rseq;
            tx_ttl   = item_ff.rttl - 8'd1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      age_in       = age_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      max_hops_in  = csr_valid ? csr_data : max_hops_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      chain_ctrl   = '{shift: 1'b0, rotate: 1'b1, entry: item_ff.rseq};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in = '{op: req_tuser, vendor: req_tdata[0], rtype: req_tdata[8:1],
                           rseq: req_tdata[16:9], rttl: req_tdata[24:17],
                           level: req_tdata[25]};
               found_in = 1'b0;
               age_in   = frdf_pkg::SEEN_AGE_W'(frdf_pkg::SEEN_DEPTH - 1);
               if (!req_tuser && req_tdata[0] && !orig_ff) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SEARCH: begin
            // The tail cell holds the entry of the age that the counter shows.
            chain_ctrl.shift = 1'b1;
            if ((chain_tail == item_ff.rseq) &&
                (frdf_pkg::SEEN_CNT_W'(age_ff) < count_ff)) begin
               found_in = 1'b1;
            end
            age_in = age_ff - frdf_pkg::SEEN_AGE_W'(1);
            if (age_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, status, orig_in, net_in, led_in,
                               tx_ttl, tx_seq, tx_type, tx_valid};
               chain_ctrl   = '{shift: record, rotate: 1'b0, entry: item_ff.rseq};
               if (record && (count_ff != frdf_pkg::SEEN_CNT_W'(frdf_pkg::SEEN_DEPTH))) begin
                  count_in = count_ff + frdf_pkg::SEEN_CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
      age_ff      <= age_in;
      found_ff    <= found_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_seq_ff  <= 8'd1;
         net_ff       <= 1'b0;
         orig_ff      <= 1'b0;
         led_ff       <= 1'b0;
         max_hops_ff  <= frdf_pkg::MAX_HOPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_hops_ff  <= max_hops_in;
         rsp_valid_ff <= rsp_valid_in;
         if ((state_ff == S_FINISH) && out_free) begin
            next_seq_ff <= next_seq_in;
            net_ff      <= net_in;
            orig_ff     <= orig_in;
            led_ff      <= led_in;
         end
      end
   end

endmodule

// File: rtl/frdf_checker.sv
module frdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // No frame is carried, the frame fields are zero.
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[24:1] == 24'd0)
      else $error("frame fields set without a frame");

   // A frame is carried exactly for a relayed or an originated result.
   a_tx_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] ==
         ((rsp_tdata[30:28] == frdf_pkg::ST_RELAYED) ||
          (rsp_tdata[30:28] == frdf_pkg::ST_ORIGINATED)))
      else $error("frame flag disagrees with status");

   // The initiator has always formed the network.
   a_init_joined: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27] |-> rsp_tdata[26])
      else $error("initiator without network");

   // An accepted beat keeps the input closed in the following cycle.
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after acceptance");

endmodule

bind flood_relay_duplicate_filter_top frdf_checker u_frdf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int STUCK_LIMIT = 4000;
   localparam int PHASE_BEATS = 137;

   typedef struct {
      bit       op;
      bit       vendor;
      bit [7:0] rtype;
      bit [7:0] rseq;
      bit [7:0] rttl;
      bit       level;
   } relay_event_type;

   typedef struct {
      bit                   tx_valid;
      bit [7:0]             tx_type;
      bit [7:0]             tx_seq;
      bit [7:0]             tx_ttl;
      bit                   led;
      bit                   joined;
      bit                   initiator;
      frdf_pkg::status_type status;
   } relay_outcome_type;

   class relay_scoreboard;
      bit [7:0]          hops = frdf_pkg::MAX_HOPS_RESET;
      bit [7:0]          seen_mem [frdf_pkg::SEEN_DEPTH];
      int                seen_cnt = 0;
      int                seen_old = 0;
      bit [7:0]          next_seq = 8'd1;
      bit                net_up = 1'b0;
      bit                origin = 1'b0;
      bit                led = 1'b0;
      relay_outcome_type awaited_outcomes [$];
      int                errors = 0;
      int                events_seen = 0;
      int                status_hits [8];

      function bit is_seen(bit [7:0] s);
         for (int i = 0; i < seen_cnt; i++) begin
            if (seen_mem[i] == s) return 1'b1;
         end
         return 1'b0;
      endfunction

      function bit [7:0] fresh_number(bit [7:0] start);
         bit [7:0] s;
         for (int k = 0; k < 256; k++) begin
            s = start + k[7:0];
            if (!is_seen(s)) return s;
         end
         return start;
      endfunction

      function relay_outcome_type predict_outcome(relay_event_type ev);
         relay_outcome_type r;
         r.tx_valid = 1'b0;
         r.tx_type = 8'd0;
         r.tx_seq = 8'd0;
         r.tx_ttl = 8'd0;
         r.status = frdf_pkg::ST_IGNORED;
         if (ev.op) begin
            if (!net_up || origin) begin
               if (!net_up) begin
                  net_up = 1'b1;
                  origin = 1'b1;
                  r.tx_type = frdf_pkg::TYPE_FORM;
               end else begin
                  led = !ev.level;
                  r.tx_type = led ? frdf_pkg::TYPE_LED_ON : frdf_pkg::TYPE_LED_OFF;
               end
               r.tx_valid = 1'b1;
               r.tx_seq = next_seq;
               r.tx_ttl = hops;
               next_seq = next_seq + 8'd1;
               r.status = frdf_pkg::ST_ORIGINATED;
            end else begin
               r.status = frdf_pkg::ST_BTN_IGNORED;
            end
         end else if (origin || !ev.vendor) begin
            r.status = frdf_pkg::ST_IGNORED;
         end else if (is_seen(ev.rseq)) begin
            r.status = frdf_pkg::ST_DUPLICATE;
         end else begin
            if (seen_cnt < frdf_pkg::SEEN_DEPTH) begin
               seen_mem[seen_cnt] = ev.rseq;
               seen_cnt++;
            end else begin
               seen_mem[seen_old] = ev.rseq;
               seen_old = (seen_old + 1) % frdf_pkg::SEEN_DEPTH;
            end
            case (ev.rtype)
               frdf_pkg::TYPE_FORM: begin
                  net_up = 1'b1;
                  origin = 1'b0;
               end
               frdf_pkg::TYPE_LED_ON: led = 1'b1;
               frdf_pkg::TYPE_LED_OFF: led = 1'b0;
               default: ;
            endcase
            if (ev.rtype > frdf_pkg::TYPE_LED_OFF) begin
               r.status = frdf_pkg::ST_INVALID;
            end else if (ev.rttl != 8'd0) begin
               r.tx_valid = 1'b1;
               r.tx_type = ev.rtype;
               r.tx_seq = ev.rseq;
               r.tx_ttl = ev.rttl - 8'd1;
               r.status = frdf_pkg::ST_RELAYED;
            end else begin
               r.status = frdf_pkg::ST_EXPIRED;
            end
         end
         r.led = led;
         r.joined = net_up;
         r.initiator = origin;
         return r;
      endfunction

      function void note_event(relay_event_type ev);
         relay_outcome_type r;
         r = predict_outcome(ev);
         events_seen++;
         status_hits[r.status]++;
         awaited_outcomes.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_outcome(bit [31:0] word);
         relay_outcome_type want;
         if (awaited_outcomes.size() == 0) begin
            errors++;
            $display("%0t: result beat %h expected none actual one", $time, word);
            return;
         end
         want = awaited_outcomes.pop_front();
         compare_field("tx_valid", 32'(want.tx_valid), 32'(word[0]));
         compare_field("tx_type", 32'(want.tx_type), 32'(word[8:1]));
         compare_field("tx_seq", 32'(want.tx_seq), 32'(word[16:9]));
         compare_field("tx_ttl", 32'(want.tx_ttl), 32'(word[24:17]));
         compare_field("led_on", 32'(want.led), 32'(word[25]));
         compare_field("joined", 32'(want.joined), 32'(word[26]));
         compare_field("initiator", 32'(want.initiator), 32'(word[27]));
         compare_field("status", 32'(want.status), 32'(word[30:28]));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   relay_scoreboard sb;
   bit              initiator_mode;
   bit              quiet_run = 1'b0;
   int              stall_left = 0;
   int              stuck_cycles = 0;

   flood_relay_duplicate_filter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_outcome(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic relay_event_type frame_ev(bit vendor, bit [7:0] t, bit [7:0] s,
                                                bit [7:0] h);
      relay_event_type ev;
      ev.op = 1'b0;
      ev.vendor = vendor;
      ev.rtype = t;
      ev.rseq = s;
      ev.rttl = h;
      ev.level = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   function automatic relay_event_type button_ev(bit level);
      relay_event_type ev;
      ev.op = 1'b1;
      ev.vendor = 1'($urandom_range(0, 1));
      ev.rtype = 8'($urandom_range(0, 255));
      ev.rseq = 8'($urandom_range(0, 255));
      ev.rttl = 8'($urandom_range(0, 255));
      ev.level = level;
      return ev;
   endfunction

   // A relay node mostly sees well-formed vendor frames, many with numbers it
   // has not seen yet, so that the seen list fills up during the run.
   function automatic relay_event_type make_event();
      relay_event_type ev;
      int              pick;
      ev = button_ev(1'($urandom_range(0, 1)));
      if (initiator_mode) begin
         ev.op = ($urandom_range(0, 3) != 0);
      end else begin
         ev.op = sb.net_up && ($urandom_range(0, 9) == 0);
         if (!ev.op) begin
            ev.vendor = ($urandom_range(0, 11) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7 && sb.seen_cnt < frdf_pkg::SEEN_DEPTH) begin
               ev.rseq = sb.fresh_number(8'($urandom_range(0, 255)));
            end else if (pick < 9 && sb.seen_cnt > 0) begin
               ev.rseq = sb.seen_mem[$urandom_range(0, sb.seen_cnt - 1)];
            end
            pick = $urandom_range(0, 19);
            if (pick < 17) begin
               ev.rtype = 8'($urandom_range(0, 2));
            end else begin
               ev.rtype = 8'($urandom_range(3, 255));
            end
            pick = $urandom_range(0, 15);
            if (pick < 2) begin
               ev.rttl = 8'd0;
            end else if (pick == 2) begin
               ev.rttl = 8'd255;
            end
         end
      end
      return ev;
   endfunction

   task automatic send_event(relay_event_type ev);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = ev.op;
      req_tdata = {6'b0, ev.level, ev.rttl, ev.rseq, ev.rtype, ev.vendor};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_event(ev);
   endtask

   task automatic req_gap();
      int n;
      if (!quiet_run && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 15);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_hops(bit [7:0] v);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.hops = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_directed();
      send_event(frame_ev(1'b0, frdf_pkg::TYPE_LED_ON, 8'd5, 8'd3));
      send_event(frame_ev(1'b1, frdf_pkg::TYPE_LED_ON, 8'd0, 8'd0));
      send_event(frame_ev(1'b1, frdf_pkg::TYPE_LED_OFF, 8'd0, 8'd9));
      send_event(frame_ev(1'b1, frdf_pkg::TYPE_LED_OFF, 8'd255, 8'd255));
      send_event(frame_ev(1'b1, 8'd255, 8'd7, 8'd4));
      send_event(frame_ev(1'b1, 8'd3, 8'd7, 8'd4));
      send_event(frame_ev(1'b1, frdf_pkg::TYPE_LED_ON, 8'd128, 8'd1));
      if (initiator_mode) begin
         send_event(button_ev(1'($urandom_range(0, 1))));
         send_event(button_ev(1'b0));
         send_event(button_ev(1'b1));
         send_event(button_ev(1'b1));
         send_event(button_ev(1'b0));
         send_event(frame_ev(1'b1, frdf_pkg::TYPE_FORM, 8'd200, 8'd5));
         send_event(frame_ev(1'b0, frdf_pkg::TYPE_LED_OFF, 8'd201, 8'd5));
      end else begin
         send_event(frame_ev(1'b1, frdf_pkg::TYPE_FORM, 8'd1, 8'd1));
         send_event(frame_ev(1'b1, frdf_pkg::TYPE_FORM, 8'd2, 8'd0));
         send_event(button_ev(1'b0));
         send_event(button_ev(1'b1));
         send_event(frame_ev(1'b1, frdf_pkg::TYPE_LED_ON, 8'd64, 8'd2));
      end
   endtask

   initial begin
      int         target;
      bit [7:0]   phase_hops [4];
      sb = new();
      // The two roles exclude each other after one reset, so the seed picks one.
      initiator_mode = ($urandom_range(0, 2) == 0);
      phase_hops[0] = 8'd0;
      phase_hops[1] = 8'($urandom_range(1, 253));
      phase_hops[2] = 8'd255;
      phase_hops[3] = 8'd254;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         write_hops(phase_hops[phase]);
         quiet_run = (phase == 3);
         target = sb.events_seen + PHASE_BEATS;
         while (sb.events_seen < target) begin
            send_event(make_event());
            if (!quiet_run && $urandom_range(0, 60) == 0) begin
               drain_results();
            end else begin
               req_gap();
            end
         end
      end
      drain_results();
      repeat (frdf_pkg::SEEN_DEPTH + 10) @(posedge clock);
      $display("Covered %0d beats as %s node: relayed %0d, expired %0d, duplicate %0d",
               sb.events_seen, initiator_mode ? "initiator" : "relay",
               sb.status_hits[frdf_pkg::ST_RELAYED], sb.status_hits[frdf_pkg::ST_EXPIRED],
               sb.status_hits[frdf_pkg::ST_DUPLICATE]);
      $display("Invalid %0d, ignored frames %0d, originated %0d, ignored buttons %0d, seen %0d",
               sb.status_hits[frdf_pkg::ST_INVALID], sb.status_hits[frdf_pkg::ST_IGNORED],
               sb.status_hits[frdf_pkg::ST_ORIGINATED],
               sb.status_hits[frdf_pkg::ST_BTN_IGNORED], sb.seen_cnt);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/frdf_pkg.sv
rtl/frdf_cell.sv
rtl/frdf_chain.sv
rtl/flood_relay_duplicate_filter_top.sv
rtl/frdf_checker.sv
sim/tb_top.sv
